// File: rtl/core/dsl_pkg.sv
// Shared types and constants of the double error syndrome locator.
// Depends on nothing; every other file of the block uses it.
package dsl_pkg;

    localparam int WORD_W      = 16;  // codeword and check row width
    localparam int SYN_W       = 8;   // syndrome width, one bit per check row
    localparam int ROW_COUNT   = 8;   // check row registers
    localparam int POS_W       = 4;   // bit position fields
    localparam int CFG_INDEX_W = 4;   // register index on the config channel
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_SINGLE = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_UNCORR = 2'd3
    } status_t;

    typedef logic [ROW_COUNT-1:0][WORD_W-1:0] rows_t;

    // Item carried from the syndrome stage to the search stages
    typedef struct packed {
        logic [SYN_W-1:0] syndrome;
        logic             zero;
    } synd_entry_t;

endpackage

// File: rtl/core/dsl_if.sv
// Channel interfaces of the double error syndrome locator.
// Depends on dsl_pkg for field widths.
interface dsl_word_if;
    logic                        valid;
    logic                        ready;
    logic [dsl_pkg::WORD_W-1:0]  received_word;

    modport source (output valid, received_word, input ready);
    modport sink   (input valid, received_word, output ready);
endinterface

interface dsl_result_if;
    logic                        valid;
    logic                        ready;
    logic [dsl_pkg::SYN_W-1:0]   syndrome;
    logic [1:0]                  status;
    logic [dsl_pkg::POS_W-1:0]   first_position;
    logic [dsl_pkg::POS_W-1:0]   second_position;

    modport source (output valid, syndrome, status, first_position, second_position,
                    input ready);
    modport sink   (input valid, syndrome, status, first_position, second_position,
                    output ready);
endinterface

interface dsl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dsl_pkg::CFG_INDEX_W-1:0]  index;
    logic [dsl_pkg::WORD_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/dsl_regs.sv
// Check row register file of the syndrome locator.
// Depends on dsl_pkg and dsl_if.
module dsl_regs #(
    parameter int CHECK_ROWS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    dsl_cfg_if.sink         cfg,
    output dsl_pkg::rows_t  rows
);
    import dsl_pkg::*;

    rows_t rows_reg;

    assign cfg.ready = 1'b1;

    // Drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
        end
        else if (cfg.valid && (cfg.index < CFG_INDEX_W'(ROW_COUNT)))
        begin
            rows_reg[cfg.index[$clog2(ROW_COUNT)-1:0]] <= cfg.data;
        end
    end

    // Rows at or above CHECK_ROWS read as zero
    always_comb
    begin
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            rows[r] = (r < CHECK_ROWS) ? rows_reg[r] : '0;
        end
    end

endmodule

// File: rtl/core/dsl_front.sv
// Front stage: accepts codewords and registers their syndrome.
// Depends on dsl_pkg and dsl_if.
module dsl_front #(
    parameter int WORD_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dsl_word_if.sink             codeword,
    input  dsl_pkg::rows_t       rows,
    output logic                 push_valid,
    output dsl_pkg::synd_entry_t push_entry,
    input  logic                 push_ready
);
    import dsl_pkg::*;

    localparam logic [WORD_W-1:0] WORD_MASK = (WORD_BITS >= WORD_W) ? '1
        : WORD_W'((64'(1) << WORD_BITS) - 64'(1));

    logic              front_valid_reg;
    logic              front_valid_next;
    synd_entry_t       front_entry_reg;
    synd_entry_t       front_entry_next;
    logic [WORD_W-1:0] word_masked;
    logic              take;

    assign codeword.ready = !front_valid_reg || push_ready;
    assign take           = codeword.valid && codeword.ready;
    assign word_masked    = codeword.received_word & WORD_MASK;

    always_comb
    begin
        front_entry_next = front_entry_reg;
        if (take)
        begin
            for (int r = 0; r < SYN_W; r++)
            begin
                front_entry_next.syndrome[r] =
                    (r < ROW_COUNT) ? ^(rows[r] & word_masked) : 1'b0;
            end
            front_entry_next.zero = (front_entry_next.syndrome == '0);
        end
        front_valid_next = take || (front_valid_reg && !push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_entry_reg <= front_entry_next;
    end

    assign push_valid = front_valid_reg;
    assign push_entry = front_entry_reg;

endmodule

// File: rtl/core/dsl_queue.sv
// Two-entry queue between the syndrome stage and the search stages.
// Depends on dsl_pkg.
module dsl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  dsl_pkg::synd_entry_t push_entry,
    output logic                 push_ready,
    output logic                 pop_valid,
    output dsl_pkg::synd_entry_t pop_entry,
    input  logic                 pop_ready
);
    import dsl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    synd_entry_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/dsl_back.sv
// Back stages: column match search, priority pick and output register.
// Depends on dsl_pkg and dsl_if.
module dsl_back #(
    parameter int WORD_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsl_pkg::rows_t       rows,
    input  logic                 pop_valid,
    input  dsl_pkg::synd_entry_t pop_entry,
    output logic                 pop_ready,
    dsl_result_if.source         result
);
    import dsl_pkg::*;

    // Columns at or above WORD_BITS are left out and never match
    localparam int COL_LIMIT = (WORD_BITS < WORD_W) ? WORD_BITS : WORD_W;

    typedef struct packed {
        logic [SYN_W-1:0]              syndrome;
        logic                          zero;
        logic                          single_any;
        logic [POS_W-1:0]              single_pos;
        logic [WORD_W-1:0]             row_any;
        logic [WORD_W-1:0][POS_W-1:0]  row_pos;
    } match_t;

    typedef struct packed {
        logic [SYN_W-1:0] syndrome;
        status_t          status;
        logic [POS_W-1:0] first_position;
        logic [POS_W-1:0] second_position;
    } out_t;

    function automatic logic [POS_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int k = WORD_W - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                pos = POS_W'(k);
            end
        end
        return pos;
    endfunction

    logic                          match_valid_reg;
    logic                          match_valid_next;
    match_t                        match_reg;
    match_t                        match_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    out_t                          out_reg;
    out_t                          out_next;
    logic                          out_ready;
    logic                          match_ready;
    logic [WORD_W-1:0][SYN_W-1:0]  cols;
    logic [WORD_W-1:0]             single_hit;
    logic [WORD_W-1:0][WORD_W-1:0] pair_hit;
    logic [POS_W-1:0]              pair_first;

    assign out_ready   = !out_valid_reg || result.ready;
    assign match_ready = !match_valid_reg || out_ready;
    assign pop_ready   = match_ready;

    // Compare every column and column pair against the syndrome
    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            for (int r = 0; r < SYN_W; r++)
            begin
                cols[j][r] = (r < ROW_COUNT) ? rows[r][j] : 1'b0;
            end
        end
        for (int i = 0; i < WORD_W; i++)
        begin
            single_hit[i] = (i < COL_LIMIT) && (cols[i] == pop_entry.syndrome);
            for (int j = 0; j < WORD_W; j++)
            begin
                pair_hit[i][j] = (j > i) && (j < COL_LIMIT)
                                 && ((cols[i] ^ cols[j]) == pop_entry.syndrome);
            end
        end
        match_next            = match_reg;
        match_next.syndrome   = pop_entry.syndrome;
        match_next.zero       = pop_entry.zero;
        match_next.single_any = |single_hit;
        match_next.single_pos = lowest_set(single_hit);
        for (int i = 0; i < WORD_W; i++)
        begin
            match_next.row_any[i] = |pair_hit[i];
            match_next.row_pos[i] = lowest_set(pair_hit[i]);
        end
        match_valid_next = (pop_valid && match_ready) || (match_valid_reg && !out_ready);
    end

    // Pick the result in search order: zero, single, then first pair, else uncorrectable
    always_comb
    begin
        pair_first                = lowest_set(match_reg.row_any);
        out_next                  = out_reg;
        out_next.syndrome         = match_reg.syndrome;
        out_next.first_position   = '0;
        out_next.second_position  = '0;
        if (match_reg.zero)
        begin
            out_next.status = ST_NONE;
        end
        else if (match_reg.single_any)
        begin
            out_next.status         = ST_SINGLE;
            out_next.first_position = match_reg.single_pos;
        end
        else if (match_reg.row_any != '0)
        begin
            out_next.status          = ST_DOUBLE;
            out_next.first_position  = pair_first;
            out_next.second_position = match_reg.row_pos[pair_first];
        end
        else
        begin
            out_next.status = ST_UNCORR;
        end
        out_valid_next = (match_valid_reg && out_ready) || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            match_valid_reg <= match_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_ready)
        begin
            match_reg <= match_next;
        end
        if (out_ready)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.syndrome        = out_reg.syndrome;
    assign result.status          = out_reg.status;
    assign result.first_position  = out_reg.first_position;
    assign result.second_position = out_reg.second_position;

    a_none_iff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.status == ST_NONE) == (out_reg.syndrome == '0)))
        else $error("status and syndrome disagree on the no error case");

    a_second_only_double: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_DOUBLE) |-> (out_reg.second_position == '0))
        else $error("second position set outside a double error");

    a_pair_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_DOUBLE)
            |-> (out_reg.first_position < out_reg.second_position))
        else $error("double error pair out of order");

    a_match_held: assert property (@(posedge clk) disable iff (!rst_n)
        (match_valid_reg && !out_ready) |=> match_valid_reg)
        else $error("match stage dropped an item while the output was stalled");

endmodule

// File: rtl/core/double_error_syndrome_locator_top.sv
// Top level of the double error syndrome locator.
// Depends on dsl_pkg, dsl_if, dsl_regs, dsl_front, dsl_queue and dsl_back.
//
// Usage:
//   cfg      - write channel for the check rows; index i writes check_row_i,
//              indexes of 8 and above are accepted and dropped. Always ready.
//              Write only while no transaction is in flight.
//   codeword - one received word per transaction.
//   result   - one transaction per word: syndrome, status (none, single,
//              double, uncorrectable) and the error positions.
// Throughput is one word per cycle while result does not stall. An accepted word
// passes the syndrome register, queue, match register and output register on
// its way to result. The queue parts the syndrome stage from the search
// stages; each side advances on its own handshake.
// When result stalls, the output and match registers hold, the queue fills,
// and codeword.ready drops only once the front register cannot drain.
// Reset clears all check rows to zero and empties every stage.
module double_error_syndrome_locator_top #(
    parameter int CHECK_ROWS = 8,
    parameter int WORD_BITS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    dsl_cfg_if.sink       cfg,
    dsl_word_if.sink      codeword,
    dsl_result_if.source  result
);
    import dsl_pkg::*;

    rows_t       rows;
    logic        push_valid;
    logic        push_ready;
    synd_entry_t push_entry;
    logic        pop_valid;
    logic        pop_ready;
    synd_entry_t pop_entry;

    // Check rows, unused rows read as zero
    dsl_regs #(
        .CHECK_ROWS (CHECK_ROWS)
    ) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rows  (rows)
    );

    // Syndrome of each accepted word
    dsl_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .codeword   (codeword),
        .rows       (rows),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    // Decouple front and back
    dsl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    // Single and pair search, then the output register
    dsl_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows      (rows),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

// File: test/tb_double_error_syndrome_locator_top.sv
// Testbench for the double error syndrome locator top level.
// Depends on dsl_pkg, dsl_if and double_error_syndrome_locator_top.
`timescale 1ns / 100ps

module tb_double_error_syndrome_locator_top;

    import dsl_pkg::*;

    localparam int CHECK_ROWS    = 8;
    localparam int WORD_BITS     = 16;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    // Pipeline latency plus margin
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_DIRECTED  = 25;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_WORDS   = 210;
    // Accepted-word count at which the receiver starts its long hold-off
    localparam int HOLD_AT_WORD  = 400;
    localparam int HOLD_CYCLES   = 300;

    // One decode report, as the result channel carries it
    typedef struct packed {
        logic [SYN_W-1:0] syndrome;
        status_t          status;
        logic [POS_W-1:0] first_position;
        logic [POS_W-1:0] second_position;
    } report_t;

    typedef enum logic {
        STEP_CFG,
        STEP_WORD
    } step_kind_t;

    // One row of the directed table: a check-row write or a word to decode,
    // with the report typed in where it is obvious by inspection
    typedef struct packed {
        step_kind_t             kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [WORD_W-1:0]      value;
        logic                   typed;
        report_t                want;
    } step_t;

    typedef enum int {
        CFG_DENSE,
        CFG_SPARSE,
        CFG_ALL_ONES,
        CFG_ALL_ZERO
    } cfg_style_t;

    logic clk;
    logic rst_n;

    dsl_cfg_if    cfg_bus ();
    dsl_word_if   word_bus ();
    dsl_result_if result_bus ();

    double_error_syndrome_locator_top #(
        .CHECK_ROWS (CHECK_ROWS),
        .WORD_BITS  (WORD_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_bus),
        .codeword (word_bus),
        .result   (result_bus)
    );

    // Shadow copy of the parity-check rows
    logic [WORD_W-1:0] h_rows [ROW_COUNT];

    report_t pending_reports [$];
    int      mismatch_count;
    int      words_accepted;
    bit      hold_done;
    bit      sender_gaps;

    // Directed table. Start from reset rows (all zero), then a single all-ones
    // row, then one-hot columns 0..7 with column 8 repeating column 0 and
    // columns 9..15 zero, then writes to unused indexes that must be dropped.
    step_t directed_steps [NUM_DIRECTED] = '{
        '{STEP_WORD, 4'd0,  16'h0000, 1'b1, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_WORD, 4'd0,  16'hFFFF, 1'b1, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_CFG,  4'd0,  16'hFFFF, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_WORD, 4'd0,  16'h0001, 1'b1, '{8'h01, ST_SINGLE, 4'd0, 4'd0}},
        '{STEP_WORD, 4'd0,  16'h0003, 1'b1, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        // every column equal: lowest one wins
        '{STEP_WORD, 4'd0,  16'h8000, 1'b1, '{8'h01, ST_SINGLE, 4'd0, 4'd0}},
        '{STEP_CFG,  4'd0,  16'h0101, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_CFG,  4'd1,  16'h0002, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_CFG,  4'd2,  16'h0004, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_CFG,  4'd3,  16'h0008, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_CFG,  4'd4,  16'h0010, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_CFG,  4'd5,  16'h0020, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_CFG,  4'd6,  16'h0040, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_CFG,  4'd7,  16'h0080, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_WORD, 4'd0,  16'h0008, 1'b1, '{8'h08, ST_SINGLE, 4'd3, 4'd0}},
        // column 8 repeats column 0
        '{STEP_WORD, 4'd0,  16'h0100, 1'b1, '{8'h01, ST_SINGLE, 4'd0, 4'd0}},
        // error in a zero column still reads as no error
        '{STEP_WORD, 4'd0,  16'h0200, 1'b1, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_WORD, 4'd0,  16'h0003, 1'b1, '{8'h03, ST_DOUBLE, 4'd0, 4'd1}},
        '{STEP_WORD, 4'd0,  16'h0007, 1'b1, '{8'h07, ST_UNCORR, 4'd0, 4'd0}},
        '{STEP_WORD, 4'd0,  16'h8081, 1'b1, '{8'h81, ST_DOUBLE, 4'd0, 4'd7}},
        '{STEP_WORD, 4'd0,  16'hFFFF, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        // indexes past the last row are accepted and dropped
        '{STEP_CFG,  4'd8,  16'hFFFF, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_CFG,  4'd15, 16'hFFFF, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}},
        '{STEP_WORD, 4'd0,  16'h0003, 1'b1, '{8'h03, ST_DOUBLE, 4'd0, 4'd1}},
        '{STEP_WORD, 4'd0,  16'h5A5A, 1'b0, '{8'h00, ST_NONE,   4'd0, 4'd0}}
    };

    // Syndrome, then lowest matching column, then first matching column pair
    function automatic report_t locate_errors(input logic [WORD_W-1:0] word);
        logic [SYN_W-1:0] column [WORD_BITS];
        report_t          rep;
        bit               found;
        rep.syndrome        = '0;
        rep.status          = ST_UNCORR;
        rep.first_position  = '0;
        rep.second_position = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            column[j] = '0;
            for (int i = 0; i < CHECK_ROWS; i++)
                column[j][i] = h_rows[i][j];
        end
        for (int i = 0; i < CHECK_ROWS; i++)
            rep.syndrome[i] = ^(h_rows[i] & word);
        found = (rep.syndrome == '0);
        if (found)
            rep.status = ST_NONE;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (!found && column[j] == rep.syndrome)
            begin
                rep.status         = ST_SINGLE;
                rep.first_position = POS_W'(j);
                found              = 1'b1;
            end
        end
        for (int i = 0; i < WORD_BITS - 1; i++)
        begin
            for (int j = i + 1; j < WORD_BITS; j++)
            begin
                if (!found && (column[i] ^ column[j]) == rep.syndrome)
                begin
                    rep.status          = ST_DOUBLE;
                    rep.first_position  = POS_W'(i);
                    rep.second_position = POS_W'(j);
                    found               = 1'b1;
                end
            end
        end
        return rep;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Mostly low-weight error patterns so single and double matches show up
    function automatic logic [WORD_W-1:0] pick_word();
        int                roll;
        int                a;
        int                b;
        logic [WORD_W-1:0] w;
        roll = $urandom_range(0, 99);
        a    = $urandom_range(0, WORD_W - 1);
        b    = $urandom_range(0, WORD_W - 1);
        while (b == a)
            b = $urandom_range(0, WORD_W - 1);
        if (roll < 10)
            w = ($urandom_range(0, 1) == 1) ? '1 : '0;
        else if (roll < 45)
            w = WORD_W'(1) << a;
        else if (roll < 75)
            w = (WORD_W'(1) << a) | (WORD_W'(1) << b);
        else if (roll < 85)
            w = (WORD_W'(1) << a) | (WORD_W'(1) << b)
                | (WORD_W'(1) << $urandom_range(0, WORD_W - 1));
        else
            w = WORD_W'($urandom);
        return w;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    // Present one word, hold it until accepted, then queue its report
    task automatic send_word(input logic [WORD_W-1:0] w, input bit typed,
                             input report_t want);
        int gap;
        @(negedge clk);
        word_bus.valid         <= 1'b1;
        word_bus.received_word <= w;
        do
            @(posedge clk);
        while (!word_bus.ready);
        words_accepted++;
        if (typed)
            pending_reports = {pending_reports, want};
        else
            pending_reports = {pending_reports, locate_errors(w)};
        // Keep valid high for back-to-back transactions; drop it only for a gap
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            word_bus.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Drop word valid, wait for every report, then let the pipeline settle
    task automatic drain_reports();
        @(negedge clk);
        word_bus.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // One check-row write; indexes past the last row leave the shadow alone
    task automatic write_row(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [WORD_W-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx < ROW_COUNT)
            h_rows[idx[$clog2(ROW_COUNT)-1:0]] = data;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Load a full matrix in the given style, plus one stray write to an
    // unused index with random data
    task automatic load_matrix(input cfg_style_t style);
        logic [WORD_W-1:0] row_val;
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            case (style)
                CFG_DENSE:    row_val = WORD_W'($urandom);
                CFG_SPARSE:   row_val = WORD_W'($urandom & $urandom & $urandom);
                CFG_ALL_ONES: row_val = '1;
                default:      row_val = '0;
            endcase
            write_row(CFG_INDEX_W'(i), row_val);
        end
        write_row(CFG_INDEX_W'($urandom_range(ROW_COUNT, 15)), WORD_W'($urandom));
    endtask

    // Receiver: random stalls, bursts of steady ready, and one long hold-off
    // once the sender has pushed enough words, so the queue fills up and
    // codeword.ready drops
    initial
    begin
        int burst;
        int stall;
        result_bus.ready <= 1'b1;
        hold_done = 1'b0;
        forever
        begin
            if (!hold_done && words_accepted >= HOLD_AT_WORD)
            begin
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            burst = $urandom_range(1, 30);
            result_bus.ready <= 1'b1;
            repeat (burst)
                @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall)
                    @(negedge clk);
            end
        end
    end

    // Check each accepted report against the oldest expectation
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report: syndrome %h status %0d pos %0d %0d",
                         $time, result_bus.syndrome, result_bus.status,
                         result_bus.first_position, result_bus.second_position);
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (result_bus.syndrome !== want.syndrome)
                begin
                    $display("%0t: syndrome expected %h actual %h",
                             $time, want.syndrome, result_bus.syndrome);
                    mismatch_count++;
                end
                if (result_bus.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, result_bus.status);
                    mismatch_count++;
                end
                if (result_bus.first_position !== want.first_position)
                begin
                    $display("%0t: first_position expected %0d actual %0d",
                             $time, want.first_position, result_bus.first_position);
                    mismatch_count++;
                end
                if (result_bus.second_position !== want.second_position)
                begin
                    $display("%0t: second_position expected %0d actual %0d",
                             $time, want.second_position, result_bus.second_position);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases under new matrices
    initial
    begin
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
        word_bus.valid         = 1'b0;
        word_bus.received_word = '0;
        mismatch_count         = 0;
        words_accepted         = 0;
        sender_gaps            = 1'b1;
        for (int i = 0; i < ROW_COUNT; i++)
            h_rows[i] = '0;
        rst_n = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; settle the pipeline before every write
        for (int s = 0; s < NUM_DIRECTED; s++)
        begin
            if (directed_steps[s].kind == STEP_CFG)
            begin
                drain_reports();
                write_row(directed_steps[s].index, directed_steps[s].value);
            end
            else
                send_word(directed_steps[s].value, directed_steps[s].typed,
                          directed_steps[s].want);
        end

        // Random phases; odd phases run the sender without gaps so the
        // long receiver hold-off backs the pipeline up
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_reports();
            if (p < 4)
                load_matrix(cfg_style_t'(p));
            else
                load_matrix(($urandom_range(0, 1) == 1) ? CFG_DENSE : CFG_SPARSE);
            sender_gaps = (p % 2 == 0);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(pick_word(), 1'b0, '0);
        end

        drain_reports();
        if (mismatch_count == 0)
            $display("tb_double_error_syndrome_locator_top passed");
        else
            $display("tb_double_error_syndrome_locator_top failed");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #20_000_000;
        $display("tb_double_error_syndrome_locator_top failed");
        $finish;
    end

endmodule
